FILE: sv/u16u8_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package u16u8_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned UnitW    = 16;
    localparam int unsigned HeldW    = 10;
    localparam int unsigned MaxBytes = 4;
    localparam int unsigned IdxW     = $clog2(MaxBytes);

    localparam logic [UnitW-1:0] HighSurBase = 16'hD800;
    localparam logic [UnitW-1:0] LowSurBase  = 16'hDC00;
    localparam logic [UnitW-1:0] SurEnd      = 16'hE000;
    localparam logic [UnitW-1:0] OneByteEnd  = 16'h0080;
    localparam logic [UnitW-1:0] TwoByteEnd  = 16'h0800;

    localparam logic [ByteW-1:0] Lead2   = 8'hC0;
    localparam logic [ByteW-1:0] Lead3   = 8'hE0;
    localparam logic [ByteW-1:0] Lead4   = 8'hF0;
    localparam logic [ByteW-1:0] ContTag = 8'h80;

    typedef logic [MaxBytes-1:0][ByteW-1:0] run_bytes_t;

    typedef struct packed {
        run_bytes_t             bytes;
        logic                   has_run;
        logic [IdxW-1:0]        last_idx;
        logic                   pending_next;
        logic [HeldW-1:0]       held_next;
    } enc_t;

endpackage

`default_nettype wire

FILE: sv/u16u8_encode.sv
`timescale 1ns / 1ps
`default_nettype none

module u16u8_encode (
    input  wire logic [u16u8_pkg::ByteW-1:0] first_byte,
    input  wire logic [u16u8_pkg::ByteW-1:0] second_byte,
    input  wire logic                        little_endian,
    input  wire logic                        pending,
    input  wire logic [u16u8_pkg::HeldW-1:0] held,
    output u16u8_pkg::enc_t                  enc
);
    import u16u8_pkg::*;

    logic [UnitW-1:0] unit;
    logic [20:0]      cp;
    logic             is_high;
    logic             is_low;

    assign unit    = little_endian ? {second_byte, first_byte} : {first_byte, second_byte};
    assign is_high = (unit >= HighSurBase) && (unit < LowSurBase);
    assign is_low  = (unit >= LowSurBase) && (unit < SurEnd);
    assign cp      = {({1'b0, held} + 11'h040), unit[HeldW-1:0]};

    always_comb
    begin
        enc              = '0;
        enc.pending_next = 1'b0;
        enc.held_next    = '0;
        if (pending)
        begin
            if (is_low)
            begin
                enc.has_run  = 1'b1;
                enc.last_idx = 2'd3;
                enc.bytes[0] = Lead4 | {5'd0, cp[20:18]};
                enc.bytes[1] = ContTag | {2'd0, cp[17:12]};
                enc.bytes[2] = ContTag | {2'd0, cp[11:6]};
                enc.bytes[3] = ContTag | {2'd0, cp[5:0]};
            end
        end
        else if (is_high)
        begin
            enc.pending_next = 1'b1;
            enc.held_next    = unit[HeldW-1:0];
        end
        else if (unit < OneByteEnd)
        begin
            enc.has_run  = 1'b1;
            enc.last_idx = 2'd0;
            enc.bytes[0] = unit[ByteW-1:0];
        end
        else if (unit < TwoByteEnd)
        begin
            enc.has_run  = 1'b1;
            enc.last_idx = 2'd1;
            enc.bytes[0] = Lead2 | {3'd0, unit[10:6]};
            enc.bytes[1] = ContTag | {2'd0, unit[5:0]};
        end
        else
        begin
            enc.has_run  = 1'b1;
            enc.last_idx = 2'd2;
            enc.bytes[0] = Lead3 | {4'd0, unit[15:12]};
            enc.bytes[1] = ContTag | {2'd0, unit[11:6]};
            enc.bytes[2] = ContTag | {2'd0, unit[5:0]};
        end
    end

endmodule

`default_nettype wire

FILE: sv/utf16_to_utf8_converter.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel    Dir  Width  Contents
// s_axis     in   16     tdata: first_byte [7:0], second_byte [15:8]
// m_axis     out  8      tdata: utf8_byte [7:0]; tlast: last_of_run
// cfg        in   1      little_endian, written when cfg_we is high
//
// One UTF-8 byte leaves per cycle from the run register while m_axis is ready; a
// unit gives one to four bytes (none for a held high surrogate or a dropped unit),
// and the output port's one byte per cycle sets the rate.
// A new word is taken in the cycle the last byte of the previous run leaves.
// rst_n clears the run, the held surrogate and little_endian.
// A stalled m_axis holds the current byte and blocks s_axis.

module utf16_to_utf8_converter (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [2*u16u8_pkg::ByteW-1:0] s_axis_tdata,  // first_byte, second_byte
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [u16u8_pkg::ByteW-1:0]        m_axis_tdata,  // utf8_byte
    output logic                               m_axis_tlast,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_wdata
);
    import u16u8_pkg::*;

    enc_t             enc;
    logic             s_fire;
    logic             m_fire;
    logic             at_last;

    logic             little_endian_reg;
    logic             pending_reg;
    logic [HeldW-1:0] held_reg;
    logic             run_valid_reg, run_valid_next;
    logic [IdxW-1:0]  run_idx_reg, run_idx_next;
    logic [IdxW-1:0]  run_last_reg;
    run_bytes_t       run_bytes_reg;

    u16u8_encode u_encode (
        .first_byte    (s_axis_tdata[ByteW-1:0]),
        .second_byte   (s_axis_tdata[2*ByteW-1:ByteW]),
        .little_endian (little_endian_reg),
        .pending       (pending_reg),
        .held          (held_reg),
        .enc           (enc)
    );

    assign at_last       = (run_idx_reg == run_last_reg);
    assign m_axis_tvalid = run_valid_reg;
    assign m_axis_tdata  = run_bytes_reg[run_idx_reg];
    assign m_axis_tlast  = at_last;
    assign s_axis_tready = !run_valid_reg || (m_axis_tready && at_last);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_fire        = run_valid_reg && m_axis_tready;

    always_comb
    begin
        run_valid_next = run_valid_reg;
        run_idx_next   = run_idx_reg;
        if (s_fire)
        begin
            run_valid_next = enc.has_run;
            run_idx_next   = '0;
        end
        else if (m_fire)
        begin
            if (at_last)
            begin
                run_valid_next = 1'b0;
            end
            else
            begin
                run_idx_next = run_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            little_endian_reg <= 1'b0;
            pending_reg       <= 1'b0;
            held_reg          <= '0;
            run_valid_reg     <= 1'b0;
            run_idx_reg       <= '0;
            run_last_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                little_endian_reg <= cfg_wdata;
            end
            run_valid_reg <= run_valid_next;
            run_idx_reg   <= run_idx_next;
            if (s_fire)
            begin
                pending_reg  <= enc.pending_next;
                held_reg     <= enc.held_next;
                run_last_reg <= enc.last_idx;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire && enc.has_run)
        begin
            run_bytes_reg <= enc.bytes;
        end
    end

endmodule

`default_nettype wire

FILE: sv/u16u8_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module u16u8_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast
);

    // stalled byte holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled output word changed");

    // reset empties the run
    assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("output valid during reset");

    // input only blocks behind a waiting run
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no output pending");

    // a taken non-final byte is followed by a continuation byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tvalid && m_axis_tdata[7:6] == 2'b10))
        else $error("run broken before its last byte");

endmodule

bind utf16_to_utf8_converter u16u8_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
